// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vwrle_pkg.sv -----
package vwrle_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BPP_W = 6;
  localparam int unsigned PIXEL_LIMIT_W = 25;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned REPS_W = 15;
  localparam int unsigned TOTAL_W = REPS_W + COUNT_W;
  localparam int unsigned DIVIDEND_W = 20;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = PIXEL_LIMIT_W;

  localparam logic [WORD_W-1:0] SLICE_MARK = 32'h534C4345;
  localparam logic [WORD_W-1:0] ESC_XOR = 32'h0000_0080;
  localparam logic [WORD_W-1:0] MAX_RUN = 32'h0000_7FFE;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [BPP_W-1:0] BPP_RESET = 6'd8;
  localparam logic [PIXEL_LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_PIXEL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_LIMIT = 1'd1;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              slice_start;
    logic              block_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  pixel_bits;
    logic [COUNT_W-1:0] pixel_count;
    logic [REPS_W-1:0]  repeat_count;
    logic               slice_full;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
  } cfg_write_t;

  typedef struct packed {
    logic accept;
    logic mark_done;
    logic load_fit;
    logic div_start;
    logic div_step;
    logic load_quo;
    logic load_rem;
  } vwrle_cmd_t;

  typedef struct packed {
    logic emit_needed;
    logic over;
    logic fits;
    logic out_free;
    logic quo_zero;
    logic rem_zero;
  } vwrle_status_t;

  // Number of pixel fields in one word for a field width of 1 to 32.
  function automatic logic [COUNT_W-1:0] fields_per_word(input logic [BPP_W-1:0] bpp);
    int unsigned cnt;
    cnt = 0;
    for (int unsigned j = 0; j < WORD_W; j++) begin
      if (j * bpp < WORD_W) begin
        cnt = cnt + 1;
      end
    end
    return COUNT_W'(cnt);
  endfunction

endpackage

// ----- sv/vwrle_stream_if.sv -----
interface vwrle_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- sv/voxel_word_rle_decoder.sv -----
// A word that yields pixels is registered on acceptance; its result is loaded from EMIT
// once the output slot is free. Input is not ready while a group is formed; a word that
// calls for no group leaves it ready. A run cut off by the pixel limit passes the bit-serial
// divider, then emits a quotient group and a remainder group, each only when nonzero.
// Reset clears the slice state and loads bits_per_pixel 8 and pixel_limit 16777216.
`include "assert_macros.svh"

module voxel_word_rle_decoder import vwrle_pkg::*; #(
  parameter int unsigned MAX_SLICE_PIXELS = 16777216
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  vwrle_stream_if.sink   in_i,
  vwrle_stream_if.source out_o,
  vwrle_stream_if.sink   cfg_i
);

  vwrle_cmd_t    cmd;
  vwrle_status_t status;
  in_item_t      in_item;
  cfg_write_t    cfg_item;
  out_item_t     out_item;
  logic          in_ready;
  logic          out_valid;
  logic          result_load;
  logic [3:0]    result_cmds;
  logic          emit_taken;

  assign in_item   = in_i.data;
  assign cfg_item  = cfg_i.data;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

  vwrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vwrle_datapath #(
    .MAX_SLICE_PIXELS (MAX_SLICE_PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item),
    .cfg_we_i    (cfg_i.valid),
    .cfg_item_i  (cfg_item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign result_load = cmd.load_fit || cmd.load_quo || cmd.load_rem;
  assign result_cmds = {cmd.load_fit, cmd.load_quo, cmd.load_rem, cmd.div_start};
  assign emit_taken  = in_i.valid && in_ready && status.emit_needed;

  `ASSERT_IMPLIES(a_load_needs_slot, result_load, status.out_free, "result slot busy")
  `ASSERT_ALWAYS(a_one_result_cmd, $onehot0(result_cmds), "conflicting result commands")
  `ASSERT_NEXT(a_busy_after_emit, emit_taken, !in_ready, "item taken while a group is formed")

endmodule

// ----- sv/vwrle_ctrl.sv -----
module vwrle_ctrl import vwrle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vwrle_status_t status_i,
  output vwrle_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMIT = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_OUTQ = 3'd3;
  localparam logic [2:0] ST_OUTR = 3'd4;

  localparam int unsigned StepW = $clog2(REPS_W);
  localparam logic [StepW-1:0] LastStep = StepW'(REPS_W - 1);

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    step_d     = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.emit_needed) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.over) begin
          cmd_o.mark_done = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.fits) begin
          if (status_i.out_free) begin
            cmd_o.load_fit = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          step_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_OUTQ;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_OUTQ: begin
        if (status_i.quo_zero) begin
          state_d = ST_OUTR;
        end else if (status_i.out_free) begin
          cmd_o.load_quo = 1'b1;
          state_d = status_i.rem_zero ? ST_IDLE : ST_OUTR;
        end
      end
      ST_OUTR: begin
        if (status_i.out_free) begin
          cmd_o.load_rem = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- sv/vwrle_datapath.sv -----
module vwrle_datapath import vwrle_pkg::*; #(
  parameter int unsigned MAX_SLICE_PIXELS = 16777216
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vwrle_cmd_t    cmd_i,
  output vwrle_status_t status_o,
  input  in_item_t      in_item_i,
  input  logic          cfg_we_i,
  input  cfg_write_t    cfg_item_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output out_item_t     out_item_o
);

  localparam int unsigned LimW = $clog2(MAX_SLICE_PIXELS + 1);
  localparam int unsigned DW = (LimW < PIXEL_LIMIT_W) ? LimW : PIXEL_LIMIT_W;
  localparam int unsigned CW = (DW > TOTAL_W) ? DW : TOTAL_W;
  localparam logic [31:0] MaxPix = 32'(MAX_SLICE_PIXELS);

  logic [BPP_W-1:0]         bpp_q;
  logic [PIXEL_LIMIT_W-1:0] limit_q;

  logic [WORD_W-1:0] prev_q, marker_q;
  logic              esc_q, cp_q, sdone_q;
  logic [DW-1:0]     done_q;

  logic [WORD_W-1:0]  emit_word_q;
  logic [REPS_W-1:0]  reps_q;
  logic [DW-1:0]      rem_q;
  logic               over_q;
  logic [COUNT_W-1:0] acc_q;
  logic [REPS_W-1:0]  quo_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic [BPP_W-1:0]   bpp_eff;
  logic [DW-1:0]      lim_eff;
  logic [COUNT_W-1:0] n_fields;
  logic [WORD_W-1:0]  top_mask, lane_bits;
  logic [10:0]        lane_off;
  logic [TOTAL_W-1:0] total;
  logic               fits, full_fit, out_free;
  logic [CW-1:0]      rem_wide;

  logic              start, w_end;
  logic [WORD_W-1:0] w, prev_e, mk_e, prev_n, mk_n, ev_word;
  logic              esc_e, cp_e, sd_e, esc_n, cp_n, sd_n, ev_emit, as_word;
  logic [REPS_W-1:0] ev_reps;
  logic [DW-1:0]     done_e;

  logic [COUNT_W:0]   div_trial;
  logic [COUNT_W:0]   div_diff;

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_q > BPP_W'(WORD_W)) begin
      bpp_eff = BPP_W'(WORD_W);
    end else begin
      bpp_eff = bpp_q;
    end
    if (limit_q == '0) begin
      lim_eff = DW'(1);
    end else if ({7'd0, limit_q} > MaxPix) begin
      lim_eff = DW'(MaxPix);
    end else begin
      lim_eff = DW'(limit_q);
    end
  end

  assign n_fields = fields_per_word(bpp_eff);

  always_comb begin
    top_mask = ~(ALL_ONES >> bpp_eff);
    lane_bits = '0;
    lane_off = '0;
    for (int j = 0; j < WORD_W; j++) begin
      lane_off = 11'(j) * 11'(bpp_eff);
      lane_bits[j] = (lane_off < 11'(WORD_W)) && (|(emit_word_q & (top_mask >> lane_off[4:0])));
    end
  end

  assign total    = TOTAL_W'(reps_q) * TOTAL_W'(n_fields);
  assign fits     = CW'(total) <= CW'(rem_q);
  assign full_fit = CW'(total) == CW'(rem_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign rem_wide = CW'(rem_q);

  always_comb begin
    w      = in_item_i.data_word;
    start  = in_item_i.slice_start;
    w_end  = in_item_i.block_end;
    prev_e = start ? SLICE_MARK : prev_q;
    mk_e   = start ? '0 : marker_q;
    esc_e  = start ? 1'b0 : esc_q;
    cp_e   = start ? 1'b0 : cp_q;
    sd_e   = start ? 1'b0 : sdone_q;
    done_e = start ? '0 : done_q;

    prev_n  = prev_e;
    mk_n    = mk_e;
    esc_n   = esc_e;
    cp_n    = cp_e;
    sd_n    = sd_e;
    ev_emit = 1'b0;
    ev_word = w;
    ev_reps = REPS_W'(1);
    as_word = 1'b1;

    if (!sd_e) begin
      if (cp_e) begin
        cp_n = 1'b0;
        if (w <= MAX_RUN) begin
          ev_emit = 1'b1;
          if (w != '0) begin
            ev_word = prev_e;
            ev_reps = w[REPS_W-1:0];
          end else begin
            ev_word = mk_e;
          end
          esc_n   = 1'b0;
          prev_n  = mk_e;
          as_word = 1'b0;
        end else begin
          prev_n = mk_e;
          esc_n  = 1'b1;
        end
      end
      if (as_word) begin
        if (esc_n && ((w ^ prev_n) == ESC_XOR)) begin
          if (!w_end) begin
            cp_n = 1'b1;
            mk_n = w;
          end
        end else begin
          ev_emit = 1'b1;
          ev_word = w;
          ev_reps = REPS_W'(1);
          prev_n  = w;
          esc_n   = 1'b1;
        end
      end
      if (w_end) begin
        sd_n = 1'b1;
        cp_n = 1'b0;
      end
    end
  end

  assign div_trial = {acc_q, quo_q[REPS_W-1]};
  assign div_diff  = div_trial - {1'b0, n_fields};

  assign status_o.emit_needed = ev_emit;
  assign status_o.over        = over_q;
  assign status_o.fits        = fits;
  assign status_o.out_free    = out_free;
  assign status_o.quo_zero    = (quo_q == '0);
  assign status_o.rem_zero    = (acc_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_item_i.reg_index)
        REG_BITS_PER_PIXEL: bpp_q   <= cfg_item_i.reg_value[BPP_W-1:0];
        REG_PIXEL_LIMIT:    limit_q <= cfg_item_i.reg_value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= SLICE_MARK;
      marker_q <= '0;
      esc_q    <= 1'b0;
      cp_q     <= 1'b0;
      sdone_q  <= 1'b0;
      done_q   <= '0;
    end else if (cmd_i.accept) begin
      prev_q   <= prev_n;
      marker_q <= mk_n;
      esc_q    <= esc_n;
      cp_q     <= cp_n;
      sdone_q  <= sd_n;
      done_q   <= done_e;
    end else begin
      if (cmd_i.mark_done) begin
        sdone_q <= 1'b1;
      end
      if (cmd_i.load_fit) begin
        done_q  <= done_q + DW'(total);
        sdone_q <= sdone_q | full_fit;
      end
      if (cmd_i.div_start) begin
        done_q  <= lim_eff;
        sdone_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      emit_word_q <= ev_word;
      reps_q      <= ev_reps;
      rem_q       <= lim_eff - done_e;
      over_q      <= done_e >= lim_eff;
    end
    if (cmd_i.div_start) begin
      acc_q <= COUNT_W'(rem_wide[DIVIDEND_W-1:REPS_W]);
      quo_q <= rem_wide[REPS_W-1:0];
    end else if (cmd_i.div_step) begin
      if (!div_diff[COUNT_W]) begin
        acc_q <= div_diff[COUNT_W-1:0];
        quo_q <= {quo_q[REPS_W-2:0], 1'b1};
      end else begin
        acc_q <= div_trial[COUNT_W-1:0];
        quo_q <= {quo_q[REPS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_fit || cmd_i.load_quo || cmd_i.load_rem) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_fit) begin
      out_item_q.pixel_bits   <= lane_bits;
      out_item_q.pixel_count  <= n_fields;
      out_item_q.repeat_count <= reps_q;
      out_item_q.slice_full   <= full_fit;
    end else if (cmd_i.load_quo) begin
      out_item_q.pixel_bits   <= lane_bits;
      out_item_q.pixel_count  <= n_fields;
      out_item_q.repeat_count <= quo_q;
      out_item_q.slice_full   <= (acc_q == '0);
    end else if (cmd_i.load_rem) begin
      out_item_q.pixel_bits   <= lane_bits & ~(ALL_ONES << acc_q);
      out_item_q.pixel_count  <= acc_q;
      out_item_q.repeat_count <= REPS_W'(1);
      out_item_q.slice_full   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
